/* rtl/alpha_over_blend_rounded_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the source-over alpha blender
// Shared property forms used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef ALPHA_OVER_BLEND_ROUNDED_ASSERT_SVH
`define ALPHA_OVER_BLEND_ROUNDED_ASSERT_SVH

// same-cycle implication, sampled on clock, off while in reset
`define AOBR_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("aobr: property failed");

// implication after a fixed number of cycles
`define AOBR_ASSERT_AFTER(label, ante, n, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##n (cons)) \
      else $error("aobr: delayed property failed");

`endif

/* rtl/aobr_pkg.sv */
// ----------------------------------------------------------------------------
// aobr_pkg
// Beat types and constants of the source-over alpha blender.
// ----------------------------------------------------------------------------
package aobr_pkg;

   localparam int unsigned ChanW     = 8;            // bits per channel
   localparam int unsigned NumColors = 3;            // red, green, blue
   localparam int unsigned NumLanes  = 4;            // colors plus alpha
   localparam int unsigned QuotW     = ChanW;        // quotient bits, one per stage
   localparam int unsigned WgtW      = 2 * ChanW;    // weights and weight sum
   localparam int unsigned ProdW     = 3 * ChanW;    // channel times weight
   localparam int unsigned NumW      = ProdW + 1;    // doubled, rounded dividend
   localparam int unsigned DvsW      = WgtW + 1;     // doubled divisor

   // lane indices
   localparam int unsigned LaneRed   = 0;
   localparam int unsigned LaneGreen = 1;
   localparam int unsigned LaneBlue  = 2;
   localparam int unsigned LaneAlpha = 3;

   localparam logic [ChanW-1:0] ChanMax      = 8'hFF;
   localparam logic [DvsW-1:0]  AlphaDivisor = 17'd510;  // 2 * 255

   typedef struct packed {
      logic [ChanW-1:0] src_red;
      logic [ChanW-1:0] src_green;
      logic [ChanW-1:0] src_blue;
      logic [ChanW-1:0] src_alpha;
      logic [ChanW-1:0] dst_red;
      logic [ChanW-1:0] dst_green;
      logic [ChanW-1:0] dst_blue;
      logic [ChanW-1:0] dst_alpha;
   } req_type;

   typedef struct packed {
      logic [ChanW-1:0] out_red;
      logic [ChanW-1:0] out_green;
      logic [ChanW-1:0] out_blue;
      logic [ChanW-1:0] out_alpha;
   } rsp_type;

   // one divider lane: partial remainder, divisor, quotient so far
   typedef struct packed {
      logic [NumW-1:0]  rem;
      logic [DvsW-1:0]  dvs;
      logic [QuotW-1:0] quo;
   } div_lane_type;

   // side data that rides along the divider
   typedef struct packed {
      logic             pass;
      logic [ChanW-1:0] dst_red;
      logic [ChanW-1:0] dst_green;
      logic [ChanW-1:0] dst_blue;
      logic [ChanW-1:0] dst_alpha;
   } side_type;

endpackage

/* rtl/alpha_over_blend_rounded.sv */
// ----------------------------------------------------------------------------
// alpha_over_blend_rounded
// Source-over compositing of a non-premultiplied RGBA8888 pixel pair with
// round-half-up results.
// ----------------------------------------------------------------------------
//  channel   ports                      handshake
//  request   start, busy, req_data      beat taken when start & !busy
//  response  rsp_valid, rsp_data        one-cycle strobe, no backpressure
//
//  One pixel pair per clock; busy is never raised.
//  The stages are capture, weights, products, dividend set-up, eight
//  restoring-divider stages (one quotient bit each), output register.
//  The eight divider stages set the depth; four lanes (R, G, B, A) run side
//  by side. Synchronous reset clears the valid bits only.
// ----------------------------------------------------------------------------
module alpha_over_blend_rounded (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  aobr_pkg::req_type req_data,
   output logic             rsp_valid,
   output aobr_pkg::rsp_type rsp_data
);

   localparam int unsigned ChanW     = aobr_pkg::ChanW;
   localparam int unsigned NumColors = aobr_pkg::NumColors;
   localparam int unsigned NumLanes  = aobr_pkg::NumLanes;
   localparam int unsigned QuotW     = aobr_pkg::QuotW;
   localparam int unsigned WgtW      = aobr_pkg::WgtW;
   localparam int unsigned ProdW     = aobr_pkg::ProdW;
   localparam int unsigned NumW      = aobr_pkg::NumW;

   // ---------------- stage 1: capture ----------------
   logic              v1_in, v1_ff;
   aobr_pkg::req_type req1_ff;

   assign busy  = 1'b0;
   assign v1_in = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
      end
      req1_ff <= req_data;
   end

   // ---------------- stage 2: weights ----------------
   logic [ChanW-1:0]  inv_alpha;
   logic [WgtW-1:0]   dw_in, dw_ff;       // da * (255 - sa)
   logic [WgtW-1:0]   sw_in, sw_ff;       // 255 * sa
   logic              v2_ff;
   aobr_pkg::req_type req2_ff;

   always_comb begin
      inv_alpha = aobr_pkg::ChanMax - req1_ff.src_alpha;
      dw_in     = {{ChanW{1'b0}}, req1_ff.dst_alpha} * {{ChanW{1'b0}}, inv_alpha};
      sw_in     = {req1_ff.src_alpha, {ChanW{1'b0}}} - {{ChanW{1'b0}}, req1_ff.src_alpha};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      dw_ff   <= dw_in;
      sw_ff   <= sw_in;
      req2_ff <= req1_ff;
   end

   // ---------------- stage 3: products and weight sum ----------------
   logic [ChanW-1:0]  src_col [NumColors];
   logic [ChanW-1:0]  dst_col [NumColors];
   logic [ProdW-1:0]  prod_s_in [NumColors];
   logic [ProdW-1:0]  prod_d_in [NumColors];
   logic [ProdW-1:0]  prod_s_ff [NumColors];
   logic [ProdW-1:0]  prod_d_ff [NumColors];
   logic [WgtW-1:0]   den_in, den_ff;
   logic              v3_ff;
   aobr_pkg::req_type req3_ff;

   always_comb begin
      src_col[aobr_pkg::LaneRed]   = req2_ff.src_red;
      src_col[aobr_pkg::LaneGreen] = req2_ff.src_green;
      src_col[aobr_pkg::LaneBlue]  = req2_ff.src_blue;
      dst_col[aobr_pkg::LaneRed]   = req2_ff.dst_red;
      dst_col[aobr_pkg::LaneGreen] = req2_ff.dst_green;
      dst_col[aobr_pkg::LaneBlue]  = req2_ff.dst_blue;
      for (int c = 0; c < NumColors; c++) begin
         prod_s_in[c] = {{WgtW{1'b0}}, src_col[c]} * {{ChanW{1'b0}}, sw_ff};
         prod_d_in[c] = {{WgtW{1'b0}}, dst_col[c]} * {{ChanW{1'b0}}, dw_ff};
      end
      // never exceeds 255*255, so no carry out
      den_in = sw_ff + dw_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      prod_s_ff <= prod_s_in;
      prod_d_ff <= prod_d_in;
      den_ff    <= den_in;
      req3_ff   <= req2_ff;
   end

   // ---------------- stage 4: dividend and divisor set-up ----------------
   // round half up: q = floor((2n + d) / 2d); alpha is round(den / 255)
   aobr_pkg::div_lane_type lane_ff [QuotW+1][NumLanes];
   aobr_pkg::side_type     side_ff [QuotW+1];
   logic                   dv_ff   [QuotW+1];
   aobr_pkg::div_lane_type lane0_in [NumLanes];
   aobr_pkg::side_type     side0_in;

   always_comb begin
      logic [ProdW-1:0] sum;
      for (int c = 0; c < NumColors; c++) begin
         sum             = prod_s_ff[c] + prod_d_ff[c];
         lane0_in[c].rem = {sum, 1'b0} + NumW'(den_ff);
         lane0_in[c].dvs = {den_ff, 1'b0};
         lane0_in[c].quo = '0;
      end
      lane0_in[aobr_pkg::LaneAlpha].rem = NumW'({den_ff, 1'b0}) + NumW'(aobr_pkg::ChanMax);
      lane0_in[aobr_pkg::LaneAlpha].dvs = aobr_pkg::AlphaDivisor;
      lane0_in[aobr_pkg::LaneAlpha].quo = '0;

      // transparent source passes the destination through
      side0_in.pass      = (req3_ff.src_alpha == '0);
      side0_in.dst_red   = req3_ff.dst_red;
      side0_in.dst_green = req3_ff.dst_green;
      side0_in.dst_blue  = req3_ff.dst_blue;
      side0_in.dst_alpha = req3_ff.dst_alpha;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else begin
         dv_ff[0] <= v3_ff;
      end
      lane_ff[0] <= lane0_in;
      side_ff[0] <= side0_in;
   end

   // ---------------- stages 5..12: restoring divider, one bit each ----------------
   for (genvar k = 0; k < QuotW; k++) begin : g_div
      localparam int unsigned Shift = QuotW - 1 - k;
      aobr_pkg::div_lane_type lane_in [NumLanes];

      always_comb begin
         logic [NumW-1:0] trial;
         for (int l = 0; l < NumLanes; l++) begin
            trial          = NumW'(lane_ff[k][l].dvs) << Shift;
            lane_in[l].dvs = lane_ff[k][l].dvs;
            if (lane_ff[k][l].rem >= trial) begin
               lane_in[l].rem = lane_ff[k][l].rem - trial;
               lane_in[l].quo = {lane_ff[k][l].quo[QuotW-2:0], 1'b1};
            end else begin
               lane_in[l].rem = lane_ff[k][l].rem;
               lane_in[l].quo = {lane_ff[k][l].quo[QuotW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k+1] <= 1'b0;
         end else begin
            dv_ff[k+1] <= dv_ff[k];
         end
         lane_ff[k+1] <= lane_in;
         side_ff[k+1] <= side_ff[k];
      end
   end

   // ---------------- stage 13: output register ----------------
   aobr_pkg::rsp_type rsp_in, rsp_ff;
   logic              rsp_valid_ff;

   always_comb begin
      if (side_ff[QuotW].pass) begin
         rsp_in.out_red   = side_ff[QuotW].dst_red;
         rsp_in.out_green = side_ff[QuotW].dst_green;
         rsp_in.out_blue  = side_ff[QuotW].dst_blue;
         rsp_in.out_alpha = side_ff[QuotW].dst_alpha;
      end else begin
         // quotients fit 8 bits, so the cap at 255 is implicit
         rsp_in.out_red   = lane_ff[QuotW][aobr_pkg::LaneRed].quo;
         rsp_in.out_green = lane_ff[QuotW][aobr_pkg::LaneGreen].quo;
         rsp_in.out_blue  = lane_ff[QuotW][aobr_pkg::LaneBlue].quo;
         rsp_in.out_alpha = lane_ff[QuotW][aobr_pkg::LaneAlpha].quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_ff[QuotW];
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* rtl/aobr_check.sv */
// ----------------------------------------------------------------------------
// aobr_check
// Port-level checks of the blender: fixed latency and the two alpha extremes.
// ----------------------------------------------------------------------------
`include "alpha_over_blend_rounded_assert.svh"

module aobr_check (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input aobr_pkg::req_type req_data,
   input logic              rsp_valid,
   input aobr_pkg::rsp_type rsp_data
);

   localparam int unsigned Latency = 13;

   // every accepted beat gives a response, checked at the Latency delay
   `AOBR_ASSERT_AFTER(a_latency, start && !busy, Latency, rsp_valid)

   // no response without an accepted beat, checked at the Latency delay
   `AOBR_ASSERT_IMPL(a_no_spurious, rsp_valid, $past(start && !busy, Latency))

   // transparent source returns the destination unchanged
   `AOBR_ASSERT_AFTER(a_transparent, start && !busy && req_data.src_alpha == 8'h00, Latency, rsp_data.out_red == $past(req_data.dst_red, Latency) && rsp_data.out_green == $past(req_data.dst_green, Latency) && rsp_data.out_blue == $past(req_data.dst_blue, Latency) && rsp_data.out_alpha == $past(req_data.dst_alpha, Latency))

   // opaque source returns the source color with full alpha
   `AOBR_ASSERT_AFTER(a_opaque, start && !busy && req_data.src_alpha == 8'hFF, Latency, rsp_data.out_alpha == 8'hFF && rsp_data.out_red == $past(req_data.src_red, Latency) && rsp_data.out_green == $past(req_data.src_green, Latency) && rsp_data.out_blue == $past(req_data.src_blue, Latency))

endmodule

bind alpha_over_blend_rounded aobr_check u_aobr_check (.*);
